// File: hdl/cpr_pkg.sv
// Shared types and constants of the circle raster painter.
// No dependencies; imported by every module of the block.
`default_nettype none
package cpr_pkg;

    localparam int COORD_W        = 20;
    localparam int DELTA_W        = 21;
    localparam int SQ_W           = 2 * DELTA_W;
    localparam int FRAC_BITS      = 8;
    localparam int ONE_Q          = 1 << FRAC_BITS;
    localparam int CHAR_W         = 8;
    localparam int OP_W           = 2;
    localparam int PIX_IDX_W      = 8;
    localparam int CFG_W          = 9;
    localparam int CFG_IDX_W      = 2;
    localparam int DIM_W          = 11;
    localparam int IN_DATA_W      = 96;
    localparam int OUT_DATA_W     = 8;
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam logic [CFG_W-1:0]  RST_WIDTH  = 9'd256;
    localparam logic [CFG_W-1:0]  RST_HEIGHT = 9'd256;
    localparam logic [CHAR_W-1:0] RST_BG     = 8'd32;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_DRAW  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BG     = 2'd2;

    localparam logic [CHAR_W-1:0] MODE_FILLED = 8'h43;
    localparam logic [CHAR_W-1:0] MODE_RIM    = 8'h63;

    typedef struct packed {
        logic start;
        logic adv_col;
        logic adv_row;
    } t_eval_ctl;

    typedef struct packed {
        logic busy;
        logic hit;
    } t_eval_sts;

endpackage
`default_nettype wire

// File: hdl/cpr_canvas_mem.sv
// Canvas byte store: one write port, one read port, registered read data.
// Depends on cpr_pkg.
`default_nettype none
module cpr_canvas_mem
    import cpr_pkg::*;
#(
    parameter int AW = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [CHAR_W-1:0] i_wdata,
    input  wire logic [AW-1:0]     i_raddr,
    output logic      [CHAR_W-1:0] o_rdata
);

    logic [CHAR_W-1:0] r_mem [0:(1 << AW)-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: hdl/cpr_circle_eval.sv
// Squared-distance engine: squares centre and radii on one multiplier,
// then steps dx^2 and dy^2 incrementally across the raster. Uses cpr_pkg.
`default_nettype none
module cpr_circle_eval
    import cpr_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_eval_ctl                 i_ctl,
    input  wire logic signed [COORD_W-1:0] i_cx,
    input  wire logic signed [COORD_W-1:0] i_cy,
    input  wire logic signed [COORD_W-1:0] i_r,
    input  wire logic                      i_filled,
    output t_eval_sts                      o_sts
);

    logic                      r_busy;
    logic [1:0]                r_phase;
    logic signed [COORD_W-1:0] r_cx, r_cy, r_r;
    logic                      r_filled, r_r1neg;
    logic signed [DELTA_W-1:0] r_dx, r_dy;
    logic signed [SQ_W-1:0]    r_sx, r_sy, r_sx0, r_r2, r_r1sq;

    logic signed [DELTA_W-1:0] mul_a;
    logic signed [SQ_W-1:0]    mul_p;
    logic signed [SQ_W-1:0]    n_sx, n_sy;
    logic signed [SQ_W:0]      d2;
    logic                      in_circle, beyond_inner;

    always_comb begin
        case (r_phase)
            2'd0:    mul_a = DELTA_W'(r_cx);
            2'd1:    mul_a = DELTA_W'(r_cy);
            2'd2:    mul_a = DELTA_W'(r_r);
            default: mul_a = DELTA_W'(r_r) - DELTA_W'(ONE_Q);
        endcase
    end

    assign mul_p = mul_a * mul_a;

    // (d + 1)^2 = d^2 + 2d + 1, with d in Q.8 units and the squares in Q.16
    assign n_sx = r_sx + (SQ_W'(r_dx) <<< (FRAC_BITS + 1)) + SQ_W'(ONE_Q * ONE_Q);
    assign n_sy = r_sy + (SQ_W'(r_dy) <<< (FRAC_BITS + 1)) + SQ_W'(ONE_Q * ONE_Q);

    assign d2           = (SQ_W+1)'(r_sx) + (SQ_W+1)'(r_sy);
    assign in_circle    = d2 <= (SQ_W+1)'(r_r2);
    assign beyond_inner = d2 > (SQ_W+1)'(r_r1sq);

    assign o_sts.busy = r_busy;
    assign o_sts.hit  = in_circle && (r_r1neg || beyond_inner || r_filled);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= '0;
        end else if (i_ctl.start) begin
            r_busy  <= 1'b1;
            r_phase <= '0;
        end else if (r_busy) begin
            r_phase <= r_phase + 2'd1;
            if (r_phase == 2'd3) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_cx     <= i_cx;
            r_cy     <= i_cy;
            r_r      <= i_r;
            r_filled <= i_filled;
            r_r1neg  <= i_r < COORD_W'(ONE_Q);
            r_dx     <= -DELTA_W'(i_cx);
            r_dy     <= -DELTA_W'(i_cy);
        end else if (r_busy) begin
            case (r_phase)
                2'd0: begin
                    r_sx0 <= mul_p;
                    r_sx  <= mul_p;
                end
                2'd1:    r_sy   <= mul_p;
                2'd2:    r_r2   <= mul_p;
                default: r_r1sq <= mul_p;
            endcase
        end else if (i_ctl.adv_row) begin
            r_dx <= -DELTA_W'(r_cx);
            r_sx <= r_sx0;
            r_dy <= r_dy + DELTA_W'(ONE_Q);
            r_sy <= n_sy;
        end else if (i_ctl.adv_col) begin
            r_dx <= r_dx + DELTA_W'(ONE_Q);
            r_sx <= n_sx;
        end
    end

endmodule
`default_nettype wire

// File: hdl/circle_raster_painter.sv
// Circle raster painter: a clear sweeps the canvas in use; a draw first squares centre and
// radii, then sweeps too (one canvas pixel visited per cycle, written on a clear or a hit);
// a read waits for the registered canvas data; errors and unused opcodes go straight to
// the response. One request at a time; the next is taken while the previous response
// waits in the output register. Synchronous active-low reset clears control and sets
// width 256, height 256, background 32; the canvas holds garbage until the first clear.
`default_nettype none
module circle_raster_painter
    import cpr_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // center_x[19:0] center_y[39:20] radius[59:40] mode_char[67:60]
    // paint_char[75:68] pixel_col[83:76] pixel_row[91:84] zero[95:92]
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,
    // opcode[1:0]
    input  wire logic [OP_W-1:0]       i_s_tuser,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // pixel_char[7:0]
    output logic [OUT_DATA_W-1:0]      o_m_tdata,
    // status[0]
    output logic                       o_m_tuser,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_W-1:0]      i_cfg_data
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int AW = CW + RW;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SETUP  = 5'b00010,
        ST_SWEEP  = 5'b00100,
        ST_RDWAIT = 5'b01000,
        ST_DONE   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;

    logic [CFG_W-1:0]  r_cfg_width, r_cfg_height;
    logic [CHAR_W-1:0] r_cfg_bg;

    logic              r_clear_mode, r_rd_ok, r_res_status;
    logic [CHAR_W-1:0] r_paint, r_res_pix;
    logic              r_out_valid, r_out_status;
    logic [CHAR_W-1:0] r_out_pix;

    logic                      s_acc, out_load;
    logic [OP_W-1:0]           in_op;
    logic signed [COORD_W-1:0] in_cx, in_cy, in_r;
    logic [CHAR_W-1:0]         in_mode, in_paint;
    logic [PIX_IDX_W-1:0]      in_col, in_row;
    logic                      draw_bad;
    logic [DIM_W-1:0]          w_ext, h_ext, w_last_d, h_last_d, col_ext, row_ext;
    logic [CW-1:0]             w_last;
    logic [RW-1:0]             h_last;

    t_eval_ctl         eval_ctl;
    t_eval_sts         eval_sts;
    logic              mem_we;
    logic [AW-1:0]     mem_raddr;
    logic [CHAR_W-1:0] mem_rdata;

    assign in_op    = i_s_tuser;
    assign in_cx    = i_s_tdata[19:0];
    assign in_cy    = i_s_tdata[39:20];
    assign in_r     = i_s_tdata[59:40];
    assign in_mode  = i_s_tdata[67:60];
    assign in_paint = i_s_tdata[75:68];
    assign in_col   = i_s_tdata[83:76];
    assign in_row   = i_s_tdata[91:84];

    assign draw_bad = (in_mode != MODE_FILLED && in_mode != MODE_RIM)
                      || in_r[COORD_W-1] || (in_r == '0);

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign out_load   = (r_state == ST_DONE) && (!r_out_valid || i_m_tready);

    // columns and rows in use, zero taken as one, saturated at the maximum
    assign w_ext = DIM_W'(r_cfg_width);
    assign h_ext = DIM_W'(r_cfg_height);

    always_comb begin
        if (w_ext == '0) begin
            w_last_d = '0;
        end else if (w_ext > DIM_W'(MAX_WIDTH)) begin
            w_last_d = DIM_W'(MAX_WIDTH - 1);
        end else begin
            w_last_d = w_ext - DIM_W'(1);
        end
        if (h_ext == '0) begin
            h_last_d = '0;
        end else if (h_ext > DIM_W'(MAX_HEIGHT)) begin
            h_last_d = DIM_W'(MAX_HEIGHT - 1);
        end else begin
            h_last_d = h_ext - DIM_W'(1);
        end
    end

    assign w_last    = w_last_d[CW-1:0];
    assign h_last    = h_last_d[RW-1:0];
    assign col_ext   = DIM_W'(in_col);
    assign row_ext   = DIM_W'(in_row);
    assign mem_raddr = {row_ext[RW-1:0], col_ext[CW-1:0]};

    always_comb begin
        n_state  = r_state;
        n_col    = r_col;
        n_row    = r_row;
        eval_ctl = '0;
        mem_we   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    n_col = '0;
                    n_row = '0;
                    case (in_op)
                        OP_CLEAR: n_state = ST_SWEEP;
                        OP_DRAW: begin
                            if (draw_bad) begin
                                n_state = ST_DONE;
                            end else begin
                                eval_ctl.start = 1'b1;
                                n_state        = ST_SETUP;
                            end
                        end
                        OP_READ: n_state = ST_RDWAIT;
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_SETUP: begin
                if (!eval_sts.busy) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                mem_we = r_clear_mode || eval_sts.hit;
                if (r_col == w_last) begin
                    n_col            = '0;
                    eval_ctl.adv_row = 1'b1;
                    if (r_row == h_last) begin
                        n_state = ST_DONE;
                    end else begin
                        n_row = r_row + RW'(1);
                    end
                end else begin
                    n_col            = r_col + CW'(1);
                    eval_ctl.adv_col = 1'b1;
                end
            end
            ST_RDWAIT: n_state = ST_DONE;
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_col        <= '0;
            r_row        <= '0;
            r_out_valid  <= 1'b0;
            r_cfg_width  <= RST_WIDTH;
            r_cfg_height <= RST_HEIGHT;
            r_cfg_bg     <= RST_BG;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WIDTH:  r_cfg_width  <= i_cfg_data;
                    CFG_HEIGHT: r_cfg_height <= i_cfg_data;
                    CFG_BG:     r_cfg_bg     <= i_cfg_data[CHAR_W-1:0];
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_clear_mode <= (in_op == OP_CLEAR);
            r_paint      <= in_paint;
            r_res_status <= (in_op == OP_DRAW) && draw_bad;
            r_res_pix    <= '0;
            r_rd_ok      <= (col_ext <= w_last_d) && (row_ext <= h_last_d);
        end else if (r_state == ST_RDWAIT) begin
            r_res_pix <= r_rd_ok ? mem_rdata : '0;
        end
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_pix    <= r_res_pix;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_pix;
    assign o_m_tuser  = r_out_status;

    cpr_circle_eval u_eval (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (eval_ctl),
        .i_cx     (in_cx),
        .i_cy     (in_cy),
        .i_r      (in_r),
        .i_filled (in_mode == MODE_FILLED),
        .o_sts    (eval_sts)
    );

    cpr_canvas_mem #(
        .AW (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr ({r_row, r_col}),
        .i_wdata (r_clear_mode ? r_cfg_bg : r_paint),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    a_bad_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && in_op == OP_DRAW && draw_bad |=> r_state == ST_DONE && r_res_status)
        else $error("rejected draw did not report error");

    a_sweep_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SWEEP |-> r_col <= w_last && r_row <= h_last)
        else $error("sweep outside canvas in use");

    a_eval_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SWEEP && !r_clear_mode |-> !eval_sts.busy)
        else $error("draw sweep before squares are ready");

    a_read_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RDWAIT |-> $past(s_acc))
        else $error("read wait without a request");

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for circle_raster_painter: clears, circle draws and pixel reads
// are streamed in and each response is checked against a canvas model held in the bench.
// Depends on cpr_pkg and the circle_raster_painter RTL only.
`timescale 1ns / 100ps

module tb;
    import cpr_pkg::*;

    localparam int CANVAS_W = DEF_MAX_WIDTH;
    localparam int CANVAS_H = DEF_MAX_HEIGHT;
    localparam int PAD_W    = IN_DATA_W - 3 * COORD_W - 2 * CHAR_W - 2 * PIX_IDX_W;

    localparam logic [OP_W-1:0]      OP_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]      opcode;
        logic [COORD_W-1:0]   center_x;
        logic [COORD_W-1:0]   center_y;
        logic [COORD_W-1:0]   radius;
        logic [CHAR_W-1:0]    mode_char;
        logic [CHAR_W-1:0]    paint_char;
        logic [PIX_IDX_W-1:0] pixel_col;
        logic [PIX_IDX_W-1:0] pixel_row;
    } canvas_req_t;

    typedef struct packed {
        logic              status;
        logic [CHAR_W-1:0] pixel_char;
    } canvas_rsp_t;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  i_s_tdata  = '0;
    logic [OP_W-1:0]       i_s_tuser  = '0;
    logic                  i_m_tready = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;
    logic                  o_s_tready;
    logic                  o_m_tvalid;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tuser;

    circle_raster_painter i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // bench copy of the block state
    logic [CHAR_W-1:0] canvas_img [0:CANVAS_W*CANVAS_H-1];
    logic [CFG_W-1:0]  width_reg  = RST_WIDTH;
    logic [CFG_W-1:0]  height_reg = RST_HEIGHT;
    logic [CHAR_W-1:0] bg_reg     = RST_BG;

    canvas_req_t pending_q [$];
    canvas_rsp_t expected_q [$];
    canvas_req_t cur_req;
    canvas_rsp_t want;
    int          error_cnt  = 0;
    int          burst_left = 0;
    int          gap_left   = 0;
    int          pat_left   = 0;
    logic [7:0]  ready_pat  = 8'hFF;

    function automatic int used_dim(logic [CFG_W-1:0] v, int maxv);
        if (v == 0) return 1;
        if (int'(v) > maxv) return maxv;
        return int'(v);
    endfunction

    // updates the canvas copy and queues the response one request causes
    task automatic apply_request(input canvas_req_t rq);
        int          w, h, col, row;
        longint      cx, cy, rr, r2, r1, r1sq, dx, dy, d2;
        canvas_rsp_t rsp;
        w   = used_dim(width_reg, CANVAS_W);
        h   = used_dim(height_reg, CANVAS_H);
        rsp = '0;
        case (rq.opcode)
            OP_CLEAR: begin
                for (row = 0; row < h; row++)
                    for (col = 0; col < w; col++)
                        canvas_img[row * CANVAS_W + col] = bg_reg;
            end
            OP_DRAW: begin
                cx = $signed(rq.center_x);
                cy = $signed(rq.center_y);
                rr = $signed(rq.radius);
                if ((rq.mode_char != MODE_FILLED && rq.mode_char != MODE_RIM) || rr <= 0) begin
                    rsp.status = 1'b1;
                end else begin
                    r2   = rr * rr;
                    r1   = rr - ONE_Q;
                    r1sq = r1 * r1;
                    for (row = 0; row < h; row++) begin
                        dy = longint'(row) * ONE_Q - cy;
                        for (col = 0; col < w; col++) begin
                            dx = longint'(col) * ONE_Q - cx;
                            d2 = dx * dx + dy * dy;
                            if (d2 <= r2 && (rq.mode_char == MODE_FILLED || r1 < 0 || d2 > r1sq))
                                canvas_img[row * CANVAS_W + col] = rq.paint_char;
                        end
                    end
                end
            end
            OP_READ: begin
                col = int'(rq.pixel_col);
                row = int'(rq.pixel_row);
                if (col < w && row < h)
                    rsp.pixel_char = canvas_img[row * CANVAS_W + col];
            end
            default: ;
        endcase
        expected_q.push_back(rsp);
    endtask

    // sender: bursts of requests with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                apply_request(cur_req);
            if (!i_s_tvalid || o_s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_s_tvalid <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    cur_req = pending_q.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {{PAD_W{1'b0}}, cur_req.pixel_row, cur_req.pixel_col,
                                   cur_req.paint_char, cur_req.mode_char, cur_req.radius,
                                   cur_req.center_y, cur_req.center_x};
                    i_s_tuser  <= cur_req.opcode;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 15);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                    end
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: rotating ready pattern, replaced now and then; checks each response
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            ready_pat = 8'hFF;
            pat_left  = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: response with nothing pending, status %0d pixel_char %h",
                             $time, o_m_tuser, o_m_tdata);
                    error_cnt++;
                end else begin
                    want = expected_q.pop_front();
                    if (o_m_tuser !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, o_m_tuser);
                        error_cnt++;
                    end
                    if (o_m_tdata !== want.pixel_char) begin
                        $display("%0t: pixel_char expected %h actual %h",
                                 $time, want.pixel_char, o_m_tdata);
                        error_cnt++;
                    end
                end
            end
            if (pat_left == 0) begin
                pat_left  = $urandom_range(8, 120);
                ready_pat = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
                if (ready_pat == 8'h00)
                    ready_pat = 8'h81;
            end
            pat_left--;
            ready_pat = {ready_pat[6:0], ready_pat[7]};
            i_m_tready <= ready_pat[0];
        end
    end

    function automatic canvas_req_t blank_req(logic [OP_W-1:0] op);
        canvas_req_t rq;
        logic [95:0] raw;
        raw       = {$urandom, $urandom, $urandom};
        rq        = raw[$bits(canvas_req_t)-1:0];
        rq.opcode = op;
        return rq;
    endfunction

    function automatic canvas_req_t draw_req(int cx, int cy, int r,
                                             logic [CHAR_W-1:0] mode, logic [CHAR_W-1:0] paint);
        canvas_req_t rq;
        rq            = blank_req(OP_DRAW);
        rq.center_x   = cx[COORD_W-1:0];
        rq.center_y   = cy[COORD_W-1:0];
        rq.radius     = r[COORD_W-1:0];
        rq.mode_char  = mode;
        rq.paint_char = paint;
        return rq;
    endfunction

    function automatic canvas_req_t read_req(int col, int row);
        canvas_req_t rq;
        rq           = blank_req(OP_READ);
        rq.pixel_col = col[PIX_IDX_W-1:0];
        rq.pixel_row = row[PIX_IDX_W-1:0];
        return rq;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_WIDTH:  width_reg  = val;
            CFG_HEIGHT: height_reg = val;
            CFG_BG:     bg_reg     = val[CHAR_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_q.size() != 0 || i_s_tvalid || expected_q.size() != 0)
            @(negedge i_clk);
    endtask

    // starts with a clear so every read inside the canvas hits a written pixel
    task automatic random_phase(input int n);
        int                w, h, span, cx, cy, r, pick;
        logic [CHAR_W-1:0] mode;
        w    = used_dim(width_reg, CANVAS_W);
        h    = used_dim(height_reg, CANVAS_H);
        span = (w > h) ? w : h;
        pending_q.push_back(blank_req(OP_CLEAR));
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                pending_q.push_back(blank_req(OP_CLEAR));
            end else if (pick < 45) begin
                if ($urandom_range(0, 9) == 0) begin
                    pending_q.push_back(blank_req(OP_DRAW));
                end else begin
                    cx = int'($urandom_range(0, (w + 2) * ONE_Q)) - ONE_Q;
                    cy = int'($urandom_range(0, (h + 2) * ONE_Q)) - ONE_Q;
                    r  = $urandom_range(1, (span / 2 + 2) * ONE_Q);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: mode = MODE_FILLED;
                        5, 6, 7, 8:    mode = MODE_RIM;
                        default:       mode = 8'($urandom);
                    endcase
                    pending_q.push_back(draw_req(cx, cy, r, mode, 8'($urandom)));
                end
            end else if (pick < 95) begin
                if ($urandom_range(0, 3) != 0)
                    pending_q.push_back(read_req($urandom_range(0, w - 1),
                                                 $urandom_range(0, h - 1)));
                else
                    pending_q.push_back(blank_req(OP_READ));
            end else begin
                pending_q.push_back(blank_req(OP_UNUSED));
            end
        end
        wait_idle();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // full-size canvas at reset values
        pending_q.push_back(blank_req(OP_CLEAR));
        pending_q.push_back(draw_req(128 * ONE_Q, 128 * ONE_Q, 40 * ONE_Q + 128,
                                     MODE_FILLED, 8'h2A));
        pending_q.push_back(draw_req(60 * ONE_Q + 64, 200 * ONE_Q + 192, 30 * ONE_Q,
                                     MODE_RIM, 8'hFF));
        pending_q.push_back(read_req(0, 0));
        pending_q.push_back(read_req(128, 128));
        pending_q.push_back(read_req(255, 255));
        pending_q.push_back(read_req(90, 200));
        wait_idle();

        // zero width and height act as one pixel; sub-pixel rim
        write_reg(CFG_WIDTH, 9'd0);
        write_reg(CFG_HEIGHT, 9'd0);
        write_reg(CFG_BG, 9'd0);
        pending_q.push_back(blank_req(OP_CLEAR));
        pending_q.push_back(draw_req(0, 0, 128, MODE_RIM, 8'hFF));
        pending_q.push_back(read_req(0, 0));
        pending_q.push_back(read_req(255, 255));
        wait_idle();

        // draw errors, unused opcode, extreme centers and radius
        write_reg(CFG_WIDTH, 9'd16);
        write_reg(CFG_HEIGHT, 9'd12);
        write_reg(CFG_BG, 9'd255);
        pending_q.push_back(blank_req(OP_CLEAR));
        pending_q.push_back(draw_req(4 * ONE_Q, 4 * ONE_Q, 0, MODE_FILLED, 8'h11));
        pending_q.push_back(draw_req(4 * ONE_Q, 4 * ONE_Q, -524288, MODE_FILLED, 8'h22));
        pending_q.push_back(draw_req(4 * ONE_Q, 4 * ONE_Q, 1000, 8'hFF, 8'h33));
        pending_q.push_back(blank_req(OP_UNUSED));
        pending_q.push_back(draw_req(-524288, 524287, 524287, MODE_FILLED, 8'h44));
        pending_q.push_back(draw_req(8 * ONE_Q, 6 * ONE_Q, 524287, MODE_FILLED, 8'h00));
        pending_q.push_back(draw_req(3 * ONE_Q, 3 * ONE_Q, 128, MODE_RIM, 8'h5A));
        pending_q.push_back(read_req(3, 3));
        pending_q.push_back(read_req(15, 11));
        pending_q.push_back(read_req(16, 0));
        wait_idle();

        // oversized width saturates
        write_reg(CFG_WIDTH, 9'd511);
        write_reg(CFG_HEIGHT, 9'd1);
        pending_q.push_back(blank_req(OP_CLEAR));
        pending_q.push_back(draw_req(524287, 0, 524287, MODE_FILLED, 8'h7E));
        pending_q.push_back(read_req(255, 0));
        wait_idle();

        write_reg(CFG_WIDTH, 9'd1);
        write_reg(CFG_HEIGHT, 9'd511);
        pending_q.push_back(blank_req(OP_CLEAR));
        pending_q.push_back(read_req(0, 255));
        wait_idle();

        // nonexistent register index must be ignored
        write_reg(CFG_NONE, 9'h1FF);

        repeat (5) begin
            write_reg(CFG_WIDTH, 9'($urandom_range(1, 40)));
            write_reg(CFG_HEIGHT, 9'($urandom_range(1, 40)));
            write_reg(CFG_BG, 9'($urandom_range(0, 255)));
            random_phase(14);
        end

        repeat (20) @(posedge i_clk);
        if (error_cnt == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial begin
        #25_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
